// ===== sv/ihpc_pkg.sv =====
// Shared constants, types and helpers for the hex record parser.
`default_nettype none
package ihpc_pkg;

  localparam int MAX_RECORD = 32;
  localparam int ADDR_W = $clog2(MAX_RECORD);
  localparam int CNT_W = $clog2(MAX_RECORD + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_RECORD);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_END = 8'h01;
  localparam logic [7:0] CMD_WRITE = 8'h03;
  localparam logic [7:0] CMD_PROGRAM = 8'h04;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_CHECKSUM = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // One queued job for the emitter: either a stop code or a buffered record.
  typedef struct packed {
    logic is_record;
    logic [1:0] kind;
    logic [7:0] addr_high;
    logic [7:0] addr_low;
    logic [7:0] length;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ihpc_if.sv =====
// Handshake interfaces for the character input and the command byte output.
`default_nettype none
interface ihpc_char_if;
  logic valid;
  logic ready;
  logic [7:0] char_code;
  logic end_of_input;
  modport source(output valid, output char_code, output end_of_input, input ready);
  modport sink(input valid, input char_code, input end_of_input, output ready);
endinterface

interface ihpc_byte_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic last;
  modport source(output valid, output out_byte, output kind, output last, input ready);
  modport sink(input valid, input out_byte, input kind, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/intel_hex_to_program_commands.sv =====
// Intel HEX parser producing programmer command bytes.
// Throughput: one character per cycle into the parser when not stalled; stop codes and
// record headers leave at one byte per cycle unless the output stalls. Each record data byte
// takes a buffer read and then a load into the output register before the next is read.
// Input stalls while the job queue is full, and a data byte waits for earlier records to drain.
// Reset (synchronous, rst high) clears all control state; the record buffer is not cleared.
`default_nettype none
module intel_hex_to_program_commands
  import ihpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  ihpc_char_if.sink   text,
  ihpc_byte_if.source cmds
);

  push_t push;
  logic q_room;
  logic head_valid;
  cmd_t head;
  logic pop;
  logic rec_done;
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0] ram_rdata;

  ihpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .push      (push),
    .q_room    (q_room),
    .rec_done  (rec_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  ihpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (q_room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ihpc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RECORD)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ihpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rec_done   (rec_done),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .cmds       (cmds)
  );

endmodule
`default_nettype wire

// ===== sv/ihpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ihpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/ihpc_front.sv =====
// Character parser: assembles record bytes, checks them and queues emit jobs.
`default_nettype none
module ihpc_front
  import ihpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  ihpc_char_if.sink        text,
  output push_t            push,
  input  wire logic        q_room,
  input  wire logic        rec_done,
  output logic             ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]       ram_wdata
);

  typedef enum logic [6:0] {
    PH_WAIT = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_ADRH = 7'b0000100,
    PH_ADRL = 7'b0001000,
    PH_TYPE = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_SUM  = 7'b1000000
  } phase_t;

  phase_t phase;
  logic [3:0] high_nibble;
  logic nibble_pending;
  logic [7:0] record_length;
  logic [7:0] address_high;
  logic [7:0] address_low;
  logic [7:0] running_sum;
  logic [CNT_W-1:0] data_count;
  logic finished;
  logic stop_pending;
  logic [1:0] rec_outstanding;

  logic accept;
  logic live;
  logic byte_done;
  logic [7:0] byte_val;
  logic [7:0] sum_add;
  logic [CNT_W-1:0] count_inc;
  logic stop_now;
  logic [1:0] stop_kind;
  logic rec_now;
  logic buf_write;

  assign byte_val = {high_nibble, digit_value(text.char_code)};
  assign sum_add = running_sum + byte_val;
  assign count_inc = data_count + 1'b1;
  assign buf_write = (phase == PH_DATA) && nibble_pending;

  // The buffer is not overwritten while the emitter still reads a record from it.
  // A stop code owed after an end-of-input record goes out with the next transfer.
  assign text.ready = finished ? (!stop_pending || q_room) :
                      (q_room && !(buf_write && (rec_outstanding != 2'd0)));
  assign accept = text.valid && text.ready;
  assign live = accept && !finished;
  assign byte_done = live && (phase != PH_WAIT) && nibble_pending;

  always_comb begin
    stop_now = 1'b0;
    stop_kind = KIND_ABORT;
    rec_now = 1'b0;
    if (byte_done) begin
      if (phase == PH_TYPE) begin
        if (byte_val == REC_END) begin
          stop_now = 1'b1;
          stop_kind = KIND_END;
        end else if (byte_val == REC_DATA && record_length > MAX_LEN) begin
          stop_now = 1'b1;
          stop_kind = KIND_ABORT;
        end
      end else if (phase == PH_SUM) begin
        if (sum_add != 8'h00) begin
          stop_now = 1'b1;
          stop_kind = KIND_CHECKSUM;
        end else begin
          rec_now = 1'b1;
        end
      end
    end
    if (live && text.end_of_input && !stop_now && !rec_now) begin
      stop_now = 1'b1;
      stop_kind = KIND_ABORT;
    end
  end

  always_comb begin
    push.valid = 1'b0;
    push.cmd.is_record = 1'b0;
    push.cmd.kind = stop_kind;
    push.cmd.addr_high = address_high;
    push.cmd.addr_low = address_low;
    push.cmd.length = record_length;
    if (stop_pending) begin
      push.valid = accept;
      push.cmd.kind = KIND_ABORT;
    end else if (rec_now) begin
      push.valid = 1'b1;
      push.cmd.is_record = 1'b1;
      push.cmd.kind = KIND_RECORD;
    end else if (stop_now) begin
      push.valid = 1'b1;
    end
  end

  assign ram_we = live && buf_write;
  assign ram_waddr = data_count[ADDR_W-1:0];
  assign ram_wdata = byte_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      high_nibble <= '0;
      nibble_pending <= 1'b0;
      record_length <= '0;
      address_high <= '0;
      address_low <= '0;
      running_sum <= '0;
      data_count <= '0;
      finished <= 1'b0;
      stop_pending <= 1'b0;
      rec_outstanding <= 2'd0;
    end else begin
      // Counts records queued or being emitted: at most one in the emitter and two queued.
      if (rec_now && !rec_done) begin
        rec_outstanding <= rec_outstanding + 2'd1;
      end else if (rec_done && !rec_now) begin
        rec_outstanding <= rec_outstanding - 2'd1;
      end
      if (stop_pending && accept) begin
        stop_pending <= 1'b0;
      end
      if (live) begin
        if (phase == PH_WAIT) begin
          if (text.char_code == CHAR_COLON) begin
            phase <= PH_LEN;
            nibble_pending <= 1'b0;
          end
        end else if (!nibble_pending) begin
          high_nibble <= digit_value(text.char_code);
          nibble_pending <= 1'b1;
        end else begin
          nibble_pending <= 1'b0;
          unique case (phase)
            PH_LEN: begin
              record_length <= byte_val;
              running_sum <= byte_val;
              phase <= PH_ADRH;
            end
            PH_ADRH: begin
              address_high <= byte_val;
              running_sum <= sum_add;
              phase <= PH_ADRL;
            end
            PH_ADRL: begin
              address_low <= byte_val;
              running_sum <= sum_add;
              phase <= PH_TYPE;
            end
            PH_TYPE: begin
              running_sum <= sum_add;
              data_count <= '0;
              if (byte_val == REC_DATA && record_length <= MAX_LEN) begin
                phase <= (record_length != 8'h00) ? PH_DATA : PH_SUM;
              end else begin
                phase <= PH_WAIT;
              end
            end
            PH_DATA: begin
              data_count <= count_inc;
              running_sum <= sum_add;
              if (8'(count_inc) >= record_length) begin
                phase <= PH_SUM;
              end
            end
            PH_SUM: begin
              running_sum <= sum_add;
              phase <= PH_WAIT;
            end
            default: begin
              phase <= PH_WAIT;
            end
          endcase
        end
        if (rec_now) begin
          // A record completed by the final character is followed by the abort code.
          if (text.end_of_input) begin
            stop_pending <= 1'b1;
            finished <= 1'b1;
          end
        end
        // Once stopped, the parser state is never looked at again until reset.
        if (stop_now) begin
          finished <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ihpc_queue.sv =====
// Two-entry job queue between the parser and the emitter.
`default_nettype none
module ihpc_queue
  import ihpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       head_valid,
  output cmd_t       head,
  input  wire logic  pop
);

  cmd_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_pop;

  assign room = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = entries[rd_ptr];
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push.valid && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push.valid) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ihpc_back.sv =====
// Emitter: turns queued jobs into command bytes, reading record data from the buffer.
`default_nettype none
module ihpc_back
  import ihpc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire cmd_t         head,
  output logic              pop,
  output logic              rec_done,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  wire logic [7:0]   ram_rdata,
  ihpc_byte_if.source       cmds
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_HEAD  = 4'b0010,
    B_DREQ  = 4'b0100,
    B_DWAIT = 4'b1000
  } back_state_t;

  back_state_t state;
  cmd_t cur;
  logic [1:0] hidx;
  logic [CNT_W-1:0] didx;
  logic out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic out_last;

  logic slot_free;
  logic load;
  logic [7:0] load_byte;
  logic [1:0] load_kind;
  logic load_last;
  logic [CNT_W-1:0] didx_inc;
  logic data_last;

  assign slot_free = !out_valid || cmds.ready;
  assign didx_inc = didx + 1'b1;
  assign data_last = (8'(didx_inc) == cur.length);

  assign cmds.valid = out_valid;
  assign cmds.out_byte = out_byte;
  assign cmds.kind = out_kind;
  assign cmds.last = out_last;

  assign ram_re = (state == B_DREQ);
  assign ram_raddr = didx[ADDR_W-1:0];

  always_comb begin
    load = 1'b0;
    load_byte = CMD_WRITE;
    load_kind = KIND_RECORD;
    load_last = 1'b0;
    pop = 1'b0;
    rec_done = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head_valid && slot_free) begin
          pop = 1'b1;
          load = 1'b1;
          if (head.is_record) begin
            load_byte = CMD_WRITE;
          end else begin
            load_byte = CMD_PROGRAM;
            load_kind = head.kind;
            load_last = 1'b1;
          end
        end
      end
      B_HEAD: begin
        if (slot_free) begin
          load = 1'b1;
          case (hidx)
            2'd1: load_byte = {1'b0, cur.addr_high[7:1]};
            2'd2: load_byte = {cur.addr_high[0], cur.addr_low[7:1]};
            default: begin
              load_byte = {1'b0, cur.length[7:1]};
              load_last = (cur.length == 8'h00);
              rec_done = (cur.length == 8'h00);
            end
          endcase
        end
      end
      B_DREQ: begin
        load = 1'b0;
      end
      B_DWAIT: begin
        if (slot_free) begin
          load = 1'b1;
          load_byte = ram_rdata;
          load_last = data_last;
          rec_done = data_last;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= load_byte;
      out_kind <= load_kind;
      out_last <= load_last;
    end
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      hidx <= 2'd0;
      didx <= '0;
    end else begin
      if (slot_free) begin
        out_valid <= load;
      end
      unique case (state)
        B_IDLE: begin
          if (pop && head.is_record) begin
            hidx <= 2'd1;
            state <= B_HEAD;
          end
        end
        B_HEAD: begin
          if (slot_free) begin
            hidx <= hidx + 2'd1;
            if (hidx == 2'd3) begin
              didx <= '0;
              state <= (cur.length == 8'h00) ? B_IDLE : B_DREQ;
            end
          end
        end
        B_DREQ: begin
          state <= B_DWAIT;
        end
        B_DWAIT: begin
          if (slot_free) begin
            didx <= didx_inc;
            state <= data_last ? B_IDLE : B_DREQ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
